### design/neighbour_mean_smoothing_macros.svh
// ============================================================================
// Assertion macros for the neighbour mean smoothing block
// Concurrent checks that compile away when SYNTH is defined.
// ============================================================================
`ifndef NEIGHBOUR_MEAN_SMOOTHING_MACROS_SVH
`define NEIGHBOUR_MEAN_SMOOTHING_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define NMS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define NMS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NMS_ASSERT_IMP(label, ante, cons, msg)
`define NMS_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

### design/nms_pkg.sv
// ============================================================================
// nms_pkg
// Types, constants and the reciprocal table of the neighbour mean smoothing.
// ============================================================================
package nms_pkg;

    // Result queue and the slot counter that claims space in it.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int CNT_W      = 4;

    // Mean magnitude and fixed-point reciprocal.
    localparam int MAG_W       = 19;
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 22;
    localparam int PROD_W      = MAG_W + RECIP_W;

    typedef enum logic [0:0] {
        REG_FRAME_ROWS = 1'b0,
        REG_FRAME_COLS = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_TAIL  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_END   = 4'b1000
    } seq_state_t;

    // One column pushed into the 3x3 window.
    typedef struct packed {
        logic vld;
        logic first;
        logic absent;
        logic emit;
        logic has_up;
        logic has_down;
        logic last;
    } feed_op_t;

    typedef struct packed {
        logic               present;
        logic signed [15:0] up;
        logic signed [15:0] mid;
        logic signed [15:0] down;
    } win_col_t;

    // ceil(2^RECIP_SHIFT / cnt) for the neighbour counts that can occur.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] k;
        case (cnt)
            4'd1:    k = 23'd4194304;
            4'd2:    k = 23'd2097152;
            4'd3:    k = 23'd1398102;
            4'd5:    k = 23'd838861;
            4'd8:    k = 23'd524288;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

### design/neighbour_mean_smoothing.sv
// ============================================================================
// neighbour_mean_smoothing
// Streams a frame in raster order and replaces each sample by the truncated
// mean of its in-frame eight neighbours, about one row behind the input.
// ============================================================================
//
//  Channel   Direction  Handshake           Payload
//  s_*       in         s_tvalid/s_tready   s_tdata[15:0] sample
//  m_*       out        m_tvalid/m_tready   m_tdata[15:0] mean_value, m_tlast
//  cfg_*     in         cfg_we              cfg_index, cfg_data
//
//  Once a result row is pending, input after the last item of a row waits while
//  a closing window column is issued; after the last item of a frame it waits
//  until the final row is swept; both use the one shared window path fed by
//  the line memory. Results pass the window and arithmetic registers to the queue.
//  Reset clears control only; the three line banks are not cleared.
//  Otherwise, an item that completes a result stalls only when the
//  eight-entry result queue has every slot claimed by results in flight or waiting.
//
`include "neighbour_mean_smoothing_macros.svh"

module neighbour_mean_smoothing #(
    parameter int MAX_COLS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [15:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [15:0] mean_value
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import nms_pkg::*;

    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    // Configuration and position.
    logic [15:0]      frame_rows_reg;
    logic [5:0]       frame_cols_reg;
    logic [15:0]      row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] flush_col_reg, flush_col_next;
    logic [1:0]       inc_bank_reg, inc_bank_next;
    logic [1:0]       new_bank_reg, new_bank_next;
    logic [1:0]       old_bank_reg, old_bank_next;
    seq_state_t       state_reg, state_next;
    logic             final_pend_reg, final_pend_next;
    logic             tail_up_reg, tail_up_next;
    logic             flush_up_reg, flush_up_next;
    logic [CNT_W-1:0] reserved_reg, reserved_next;

    logic [COL_W-1:0] last_col;
    logic [15:0]      last_row;
    logic             row_ge1, row_ge2, at_last_col, item_final, item_emits;
    logic             credit_ok, in_acc, issue_emit, pop;

    // Line memory: three rotating banks (incoming, newer, older row).
    logic [15:0]      line_mem [0:2][0:MAX_COLS-1];
    logic             mem_we;
    logic [1:0]       rd_a_bank, rd_b_bank;
    logic [COL_W-1:0] rd_a_col, rd_b_col;
    logic [15:0]      q_a_reg, q_b_reg;

    feed_op_t         op, op1_reg, op2_reg;
    logic [15:0]      sample1_reg;
    win_col_t         win_left_reg, win_centre_reg, win_right_reg;

    // Arithmetic pipeline.
    logic signed [15:0] lu, lm, ld, ru, rm, rd;
    logic signed [17:0] up_sum, dn_sum;
    logic signed [16:0] mid_sum;
    logic [CNT_W-1:0]   side_cnt, row_cnt, cnt;
    logic signed [17:0] up3_reg, dn3_reg;
    logic signed [16:0] mid3_reg;
    logic [CNT_W-1:0]   cnt3_reg, cnt4_reg;
    logic               vld3_reg, last3_reg, vld4_reg, last4_reg;
    logic signed [MAG_W-1:0] total4_reg;
    logic [MAG_W-1:0]   total_u, mag;
    logic [MAG_W-1:0]   mag5_reg;
    logic [RECIP_W-1:0] recip5_reg;
    logic               neg5_reg, vld5_reg, last5_reg;
    logic [PROD_W-1:0]  prod6_reg;
    logic               neg6_reg, vld6_reg, last6_reg;
    logic [MAG_W-1:0]   quot;
    logic [15:0]        mean;

    // Result queue.
    logic [16:0]        fifo_mem [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   fifo_cnt_reg;

    // ------------------------------------------------------------------------
    // Frame geometry
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (frame_cols_reg == 6'd0)
        begin
            last_col = '0;
        end
        else if (frame_cols_reg > 6'(MAX_COLS))
        begin
            last_col = COL_W'(MAX_COLS - 1);
        end
        else
        begin
            last_col = COL_W'(frame_cols_reg - 6'd1);
        end
    end

    assign last_row    = (frame_rows_reg == 16'd0) ? 16'd0 : frame_rows_reg - 16'd1;
    assign row_ge1     = (row_reg != 16'd0);
    assign row_ge2     = (row_reg > 16'd1);
    assign at_last_col = (col_reg == last_col);
    assign item_final  = (row_reg == last_row) && at_last_col;
    assign item_emits  = row_ge1 && (col_reg != '0);
    assign credit_ok   = (reserved_reg < CNT_W'(FIFO_DEPTH));
    assign s_tready    = (state_reg == S_IDLE) && (credit_ok || !item_emits);
    assign in_acc      = s_tvalid && s_tready;

    // ------------------------------------------------------------------------
    // Sequencer: unless held for input or for queue slots, issues one window column per cycle
    // ------------------------------------------------------------------------
    always_comb
    begin
        op              = '0;
        mem_we          = 1'b0;
        rd_a_bank       = old_bank_reg;
        rd_b_bank       = new_bank_reg;
        rd_a_col        = col_reg;
        rd_b_col        = col_reg;
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        flush_col_next  = flush_col_reg;
        inc_bank_next   = inc_bank_reg;
        new_bank_next   = new_bank_reg;
        old_bank_next   = old_bank_reg;
        final_pend_next = final_pend_reg;
        tail_up_next    = tail_up_reg;
        flush_up_next   = flush_up_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op.vld      = 1'b1;
                    op.first    = (col_reg == '0);
                    op.emit     = item_emits;
                    op.has_up   = row_ge2;
                    op.has_down = 1'b1;
                    mem_we      = 1'b1;
                    tail_up_next = row_ge2;
                    if (item_final)
                    begin
                        final_pend_next = 1'b1;
                        flush_up_next   = row_ge1;
                        flush_col_next  = '0;
                        row_next        = 16'd0;
                        col_next        = '0;
                        state_next      = row_ge1 ? S_TAIL : S_FLUSH;
                    end
                    else if (at_last_col)
                    begin
                        // The incoming row becomes the newer one; the older
                        // bank is reused for the next row.
                        final_pend_next = 1'b0;
                        row_next        = row_reg + 16'd1;
                        col_next        = '0;
                        old_bank_next   = new_bank_reg;
                        new_bank_next   = inc_bank_reg;
                        inc_bank_next   = old_bank_reg;
                        if (row_ge1)
                        begin
                            state_next = S_TAIL;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
            end
            S_TAIL:
            begin
                if (credit_ok)
                begin
                    op.vld      = 1'b1;
                    op.absent   = 1'b1;
                    op.emit     = 1'b1;
                    op.has_up   = tail_up_reg;
                    op.has_down = 1'b1;
                    state_next  = final_pend_reg ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH:
            begin
                // The final row is swept with the newer row above it.
                rd_a_bank = new_bank_reg;
                rd_b_bank = inc_bank_reg;
                rd_a_col  = flush_col_reg;
                rd_b_col  = flush_col_reg;
                if (credit_ok || (flush_col_reg == '0))
                begin
                    op.vld    = 1'b1;
                    op.first  = (flush_col_reg == '0);
                    op.emit   = (flush_col_reg != '0);
                    op.has_up = flush_up_reg;
                    if (flush_col_reg == last_col)
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        flush_col_next = flush_col_reg + COL_W'(1);
                    end
                end
            end
            S_END:
            begin
                if (credit_ok)
                begin
                    op.vld     = 1'b1;
                    op.absent  = 1'b1;
                    op.emit    = 1'b1;
                    op.has_up  = flush_up_reg;
                    op.last    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign issue_emit    = op.vld && op.emit;
    assign pop           = m_tvalid && m_tready;
    assign reserved_next = reserved_reg + CNT_W'(issue_emit) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg <= 16'd1;
            frame_cols_reg <= 6'd1;
            row_reg        <= '0;
            col_reg        <= '0;
            flush_col_reg  <= '0;
            inc_bank_reg   <= 2'd0;
            new_bank_reg   <= 2'd1;
            old_bank_reg   <= 2'd2;
            state_reg      <= S_IDLE;
            final_pend_reg <= 1'b0;
            tail_up_reg    <= 1'b0;
            flush_up_reg   <= 1'b0;
            reserved_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            flush_col_reg  <= flush_col_next;
            inc_bank_reg   <= inc_bank_next;
            new_bank_reg   <= new_bank_next;
            old_bank_reg   <= old_bank_next;
            final_pend_reg <= final_pend_next;
            tail_up_reg    <= tail_up_next;
            flush_up_reg   <= flush_up_next;
            reserved_reg   <= reserved_next;
            if (cfg_we)
            begin
                // A register write restarts the frame.
                row_reg <= '0;
                col_reg <= '0;
                case (cfg_index)
                    REG_FRAME_ROWS: frame_rows_reg <= cfg_data;
                    REG_FRAME_COLS: frame_cols_reg <= cfg_data[5:0];
                    default:        frame_rows_reg <= frame_rows_reg;
                endcase
            end
            else
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Line memory, one write and two registered reads
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[inc_bank_reg][col_reg] <= s_tdata;
        end
        q_a_reg <= line_mem[rd_a_bank][rd_a_col];
        q_b_reg <= line_mem[rd_b_bank][rd_b_col];
    end

    always_ff @(posedge clk)
    begin
        sample1_reg <= s_tdata;
    end

    // ------------------------------------------------------------------------
    // 3x3 window, shifted by one column per issued item
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op1_reg        <= '0;
            op2_reg        <= '0;
            win_left_reg   <= '0;
            win_centre_reg <= '0;
            win_right_reg  <= '0;
        end
        else
        begin
            op1_reg <= op;
            op2_reg <= op1_reg;
            if (op1_reg.vld)
            begin
                win_left_reg <= win_centre_reg;
                // At the start of a row nothing lies left of column zero.
                if (op1_reg.first)
                begin
                    win_centre_reg <= '0;
                end
                else
                begin
                    win_centre_reg <= win_right_reg;
                end
                win_right_reg.present <= !op1_reg.absent;
                win_right_reg.up      <= q_a_reg;
                win_right_reg.mid     <= q_b_reg;
                win_right_reg.down    <= sample1_reg;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Row sums and neighbour count
    // ------------------------------------------------------------------------
    always_comb
    begin
        lu = win_left_reg.present  ? win_left_reg.up    : '0;
        lm = win_left_reg.present  ? win_left_reg.mid   : '0;
        ld = win_left_reg.present  ? win_left_reg.down  : '0;
        ru = win_right_reg.present ? win_right_reg.up   : '0;
        rm = win_right_reg.present ? win_right_reg.mid  : '0;
        rd = win_right_reg.present ? win_right_reg.down : '0;
        up_sum  = op2_reg.has_up ? (18'(lu) + 18'(win_centre_reg.up) + 18'(ru)) : '0;
        dn_sum  = op2_reg.has_down ? (18'(ld) + 18'(win_centre_reg.down) + 18'(rd)) : '0;
        mid_sum = 17'(lm) + 17'(rm);
        side_cnt = CNT_W'(win_left_reg.present) + CNT_W'(win_right_reg.present);
        row_cnt  = side_cnt + CNT_W'(1);
        cnt = side_cnt + (op2_reg.has_up ? row_cnt : '0) + (op2_reg.has_down ? row_cnt : '0);
    end

    // Magnitude of the total; the pattern of the most negative sum maps to 2^18.
    assign total_u = MAG_W'(total4_reg);
    assign mag     = total4_reg[MAG_W-1] ? (~total_u + MAG_W'(1)) : total_u;
    assign quot    = prod6_reg[RECIP_SHIFT +: MAG_W];
    assign mean    = neg6_reg ? 16'(~quot + MAG_W'(1)) : 16'(quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
        end
        else
        begin
            vld3_reg <= op2_reg.vld && op2_reg.emit;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
            vld6_reg <= vld5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        up3_reg    <= up_sum;
        mid3_reg   <= mid_sum;
        dn3_reg    <= dn_sum;
        cnt3_reg   <= cnt;
        last3_reg  <= op2_reg.last;
        total4_reg <= MAG_W'(up3_reg) + MAG_W'(mid3_reg) + MAG_W'(dn3_reg);
        cnt4_reg   <= cnt3_reg;
        last4_reg  <= last3_reg;
        mag5_reg   <= mag;
        recip5_reg <= recip_of(cnt4_reg);
        neg5_reg   <= total4_reg[MAG_W-1];
        last5_reg  <= last4_reg;
        prod6_reg  <= PROD_W'(mag5_reg) * PROD_W'(recip5_reg);
        neg6_reg   <= neg5_reg;
        last6_reg  <= last5_reg;
    end

    // ------------------------------------------------------------------------
    // Result queue; slots are claimed when a result column is issued
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (vld6_reg)
        begin
            fifo_mem[wr_ptr_reg] <= {last6_reg, mean};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (vld6_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + CNT_W'(vld6_reg) - CNT_W'(pop);
        end
    end

    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = fifo_mem[rd_ptr_reg][15:0];
    assign m_tlast  = fifo_mem[rd_ptr_reg][16];

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `NMS_ASSERT_IMP(a_slots, 1'b1, (fifo_cnt_reg <= reserved_reg) && (reserved_reg <= CNT_W'(FIFO_DEPTH)), "result queue slot count out of step")
    `NMS_ASSERT_IMP(a_col_range, 1'b1, col_reg <= last_col, "column position beyond the row")
    `NMS_ASSERT_NXT(a_final_flush, in_acc && item_final && !cfg_we, state_reg != S_IDLE, "final item did not start the flush")
    `NMS_ASSERT_IMP(a_centre, op2_reg.vld && op2_reg.emit, win_centre_reg.present, "result taken from an empty window centre")

endmodule
